### hdl/six_patch_sphere_to_cartesian_core_assert.svh
// Assertion macros shared by the sphere-to-Cartesian core.
// Both sample on the rising edge of i_clk and stay quiet while i_rst_n is low.
`ifndef SIX_PATCH_SPHERE_TO_CARTESIAN_CORE_ASSERT_SVH
`define SIX_PATCH_SPHERE_TO_CARTESIAN_CORE_ASSERT_SVH

// Same-cycle implication.
`define SP2C_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SP2C_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sp2c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sp2c_pkg
// Shared constants and types for the cube-face sphere to Cartesian core.
// ----------------------------------------------------------------------------
package sp2c_pkg;

    // Fixed-point scaling
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [16:0] ANGLE_MAX = 17'd51472;

    // Horner series divisors, innermost term first
    localparam int unsigned HORNER_STEPS = 6;
    localparam int unsigned SIN_DIV [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [HORNER_STEPS] = '{132, 90, 56, 30, 12, 2};

    // Tangent in Q30, with headroom above 1.0
    localparam int unsigned TAN_W = 32;
    typedef logic [TAN_W-1:0] t_tan;

    // Face codes
    localparam logic [2:0] PATCH_PX = 3'd0;
    localparam logic [2:0] PATCH_MX = 3'd1;
    localparam logic [2:0] PATCH_PY = 3'd2;
    localparam logic [2:0] PATCH_MY = 3'd3;
    localparam logic [2:0] PATCH_PZ = 3'd4;
    localparam logic [2:0] PATCH_MZ = 3'd5;

    // Register indexes
    localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_Z = 2'd2;

endpackage

### hdl/six_patch_sphere_to_cartesian_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_patch_sphere_to_cartesian_core
// Cube-face patch point (face, two angles, radius) to saturated Cartesian x, y, z.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries face, angle_a, angle_b and
//   radial distance; output channel o_out_valid / i_out_ready returns pos_x,
//   pos_y, pos_z and the saturated flag. One result per input, in order.
//   Throughput is one transfer per cycle while the skid register is empty:
//   every step is a cell of a fixed chain (series cells, one-bit divide cells,
//   one-bit square root cells). From input transfer to output valid a result
//   passes front end, series (6 cells of 3), sine, tangent divide, radicand,
//   root, radius divide, multiply and the output register, in that order.
//   When the receiver stalls, a result that finds the output register full
//   lands in a skid register, so one more input is still taken; with the skid
//   full the whole chain holds and o_in_ready drops.
//   Origin registers are written through i_cfg_we / i_cfg_idx / i_cfg_data and
//   should change only while the block is empty. Index 3 is ignored.
//   Synchronous reset clears all valid bits and sets the origin to zero.
// ----------------------------------------------------------------------------
module six_patch_sphere_to_cartesian_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_patch,
    input  logic signed [16:0]  i_angle_a,
    input  logic signed [16:0]  i_angle_b,
    input  logic [30:0]         i_radial_distance,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic                o_saturated,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    import sp2c_pkg::*;

    `include "six_patch_sphere_to_cartesian_core_assert.svh"

    localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
    localparam logic [31:0] POS_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]  patch;
        logic [30:0] r;
    } t_in_side;

    typedef struct packed {
        logic [2:0]  patch;
        logic [30:0] r;
        t_tan        ta;
        t_tan        tb;
        logic        na;
        logic        nb;
    } t_root_side;

    typedef struct packed {
        logic [2:0]  patch;
        t_tan        ta;
        t_tan        tb;
        logic        na;
        logic        nb;
    } t_quot_side;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        sat;
    } t_result;

    // advance the whole chain unless the skid register is occupied
    logic adv;
    logic r_skid_v;
    assign adv        = ~r_skid_v;
    assign o_in_ready = adv;

    // origin registers
    logic [31:0] r_org [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org <= '{32'd0, 32'd0, 32'd0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X: r_org[0] <= i_cfg_data;
                CFG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                CFG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tangent of both angles
    t_in_side tan_in_sb;
    t_in_side tan_out_sb;
    logic     tan_v;
    t_tan     tan_a;
    t_tan     tan_b;
    logic     tan_na;
    logic     tan_nb;

    assign tan_in_sb = '{patch: i_patch, r: i_radial_distance};

    sp2c_tan #(
        .SW ($bits(t_in_side))
    ) u_tan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (i_in_valid & adv),
        .i_angle_a (i_angle_a),
        .i_angle_b (i_angle_b),
        .i_sb      (tan_in_sb),
        .o_valid   (tan_v),
        .o_ta      (tan_a),
        .o_tb      (tan_b),
        .o_na      (tan_na),
        .o_nb      (tan_nb),
        .o_sb      (tan_out_sb)
    );

    // radicand 1 + ta^2 + tb^2 in Q30
    logic [63:0] sq_a;
    logic [63:0] sq_b;
    logic [34:0] qsum;
    logic        r_q1_v;
    logic [33:0] r_q1_pa;
    logic [33:0] r_q1_pb;
    t_root_side  r_q1_side;
    logic        r_q2_v;
    logic [31:0] r_q2_q;
    t_root_side  r_q2_side;

    assign sq_a = 64'(tan_a) * 64'(tan_a);
    assign sq_b = 64'(tan_b) * 64'(tan_b);
    assign qsum = 35'(Q30_ONE) + 35'(r_q1_pa) + 35'(r_q1_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_v <= 1'b0;
            r_q2_v <= 1'b0;
        end else if (adv) begin
            r_q1_v <= tan_v;
            r_q2_v <= r_q1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q1_pa   <= sq_a[63:30];
            r_q1_pb   <= sq_b[63:30];
            r_q1_side <= '{patch: tan_out_sb.patch, r: tan_out_sb.r,
                           ta: tan_a, tb: tan_b, na: tan_na, nb: tan_nb};
            r_q2_q    <= qsum[31:0];
            r_q2_side <= r_q1_side;
        end
    end

    // root of the radicand scaled by 2^30
    localparam int unsigned ROOT_STEPS = 31;

    logic        sv    [ROOT_STEPS+1];
    logic [32:0] srem  [ROOT_STEPS+1];
    logic [30:0] sroot [ROOT_STEPS+1];
    logic [61:0] slow  [ROOT_STEPS+1];
    t_root_side  ssb   [ROOT_STEPS+1];

    assign sv[0]    = r_q2_v;
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign slow[0]  = {r_q2_q, 30'd0};
    assign ssb[0]   = r_q2_side;

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
        sp2c_sqrt_cell #(
            .SW ($bits(t_root_side))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (sv[g]),
            .i_rem   (srem[g]),
            .i_root  (sroot[g]),
            .i_low   (slow[g]),
            .i_sb    (ssb[g]),
            .o_valid (sv[g+1]),
            .o_rem   (srem[g+1]),
            .o_root  (sroot[g+1]),
            .o_low   (slow[g+1]),
            .o_sb    (ssb[g+1])
        );
    end

    // s = (r << 30) / root
    localparam int unsigned S_W = 31;

    t_root_side  root_side;
    logic        dv    [S_W+1];
    logic [30:0] drem  [S_W+1][1];
    logic [S_W-1:0] dlow  [S_W+1][1];
    logic [S_W-1:0] dquot [S_W+1][1];
    logic [30:0] ddiv  [S_W+1][1];
    t_quot_side  dsb   [S_W+1];

    assign root_side  = ssb[ROOT_STEPS];
    assign dv[0]      = sv[ROOT_STEPS];
    assign drem[0][0] = {1'b0, root_side.r[30:1]};
    assign dlow[0][0] = {root_side.r[0], 30'd0};
    assign dquot[0][0] = '0;
    assign ddiv[0][0] = sroot[ROOT_STEPS];
    assign dsb[0]     = '{patch: root_side.patch, ta: root_side.ta, tb: root_side.tb,
                          na: root_side.na, nb: root_side.nb};

    for (genvar g = 0; g < S_W; g++) begin : g_sdiv
        sp2c_div_cell #(
            .LANES (1),
            .DW    (31),
            .QW    (S_W),
            .SW    ($bits(t_quot_side))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (dv[g]),
            .i_rem   (drem[g]),
            .i_low   (dlow[g]),
            .i_quot  (dquot[g]),
            .i_div   (ddiv[g]),
            .i_sb    (dsb[g]),
            .o_valid (dv[g+1]),
            .o_rem   (drem[g+1]),
            .o_low   (dlow[g+1]),
            .o_quot  (dquot[g+1]),
            .o_div   (ddiv[g+1]),
            .o_sb    (dsb[g+1])
        );
    end

    // s * ta and s * tb
    logic [62:0] mul_a;
    logic [62:0] mul_b;
    logic        r_m_v;
    logic [30:0] r_m_s;
    logic [32:0] r_m_sa;
    logic [32:0] r_m_sb;
    t_quot_side  r_m_side;

    assign mul_a = 63'(dquot[S_W][0]) * 63'(dsb[S_W].ta);
    assign mul_b = 63'(dquot[S_W][0]) * 63'(dsb[S_W].tb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (adv) begin
            r_m_v <= dv[S_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_s    <= dquot[S_W][0];
            r_m_sa   <= mul_a[62:30];
            r_m_sb   <= mul_b[62:30];
            r_m_side <= dsb[S_W];
        end
    end

    // signed, permuted terms added to the origin and clamped
    logic        minus;
    logic [34:0] t_face;
    logic [34:0] t_ta;
    logic [34:0] t_tb;
    logic [34:0] term [3];
    logic [34:0] sum  [3];
    logic [31:0] clamped [3];
    logic [2:0]  hit;
    t_result     res;

    always_comb begin
        minus  = r_m_side.patch[0];
        t_face = minus ? 35'd0 - 35'(r_m_s) : 35'(r_m_s);
        t_ta   = (r_m_side.na ^ minus) ? 35'd0 - 35'(r_m_sa) : 35'(r_m_sa);
        t_tb   = (r_m_side.nb ^ minus) ? 35'd0 - 35'(r_m_sb) : 35'(r_m_sb);
        case (r_m_side.patch) inside
            PATCH_PX, PATCH_MX: begin
                term[0] = t_face;
                term[1] = t_tb;
                term[2] = t_ta;
            end
            PATCH_PY, PATCH_MY: begin
                term[0] = t_tb;
                term[1] = t_face;
                term[2] = t_ta;
            end
            PATCH_PZ, PATCH_MZ: begin
                term[0] = t_tb;
                term[1] = t_ta;
                term[2] = t_face;
            end
            default: begin
                // unused face codes leave the origin as it is
                term[0] = '0;
                term[1] = '0;
                term[2] = '0;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            sum[i] = {{3{r_org[i][31]}}, r_org[i]} + term[i];
            if (!sum[i][34] && (sum[i][33:31] != 3'b000)) begin
                clamped[i] = POS_MAX;
                hit[i]     = 1'b1;
            end else if (sum[i][34] && (sum[i][33:31] != 3'b111)) begin
                clamped[i] = POS_MIN;
                hit[i]     = 1'b1;
            end else begin
                clamped[i] = sum[i][31:0];
                hit[i]     = 1'b0;
            end
        end
        res = '{x: clamped[0], y: clamped[1], z: clamped[2], sat: |hit};
    end

    // output register and skid
    logic    take;
    logic    out_free;
    logic    r_out_v;
    t_result r_out;
    t_result r_skid;

    assign take     = adv & r_m_v;
    assign out_free = ~r_out_v | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= take;
            end
        end else if (take) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (take) begin
            r_skid <= res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_pos_x     = r_out.x;
    assign o_pos_y     = r_out.y;
    assign o_pos_z     = r_out.z;
    assign o_saturated = r_out.sat;

    // skid is only ever filled behind a full output register
    `SP2C_ASSERT_IMP(a_skid_behind_out, r_skid_v, r_out_v, "skid full with output empty")
    // a result meeting a stalled output must land in the skid
    `SP2C_ASSERT_NXT(a_stall_spills, take && r_out_v && !i_out_ready, r_skid_v,
                     "stalled result lost")
    // the flag only rises together with a clamped coordinate
    `SP2C_ASSERT_IMP(a_sat_clamped, r_out_v && r_out.sat,
                     (r_out.x == POS_MAX) || (r_out.x == POS_MIN) ||
                     (r_out.y == POS_MAX) || (r_out.y == POS_MIN) ||
                     (r_out.z == POS_MAX) || (r_out.z == POS_MIN),
                     "saturated flag without a clamped coordinate")

endmodule

### hdl/sp2c_horner_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sp2c_horner_cell
// One Horner step of the sine and cosine series for two angles, three stages.
// ----------------------------------------------------------------------------
module sp2c_horner_cell #(
    parameter int unsigned SW = 1,
    parameter int unsigned DS = 6,
    parameter int unsigned DC = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [29:0]   i_x  [2],
    input  logic [29:0]   i_x2 [2],
    input  logic [30:0]   i_t  [4],
    input  logic [SW-1:0] i_sb,
    output logic          o_valid,
    output logic [29:0]   o_x  [2],
    output logic [29:0]   o_x2 [2],
    output logic [30:0]   o_t  [4],
    output logic [SW-1:0] o_sb
);
    import sp2c_pkg::*;

    // reciprocal of each divisor, 32 fractional bits, rounded down
    localparam logic [31:0] MUL_S = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MUL_C = 32'((64'd1 << 32) / DC);
    localparam logic [31:0] MULS [4] = '{MUL_S, MUL_C, MUL_S, MUL_C};
    localparam logic [7:0]  DIVS [4] = '{8'(DS), 8'(DC), 8'(DS), 8'(DC)};

    logic          r_v  [3];
    logic [29:0]   r_x  [3][2];
    logic [29:0]   r_x2 [3][2];
    logic [SW-1:0] r_sb [3];
    logic [29:0]   r_p1 [4];
    logic [29:0]   r_p2 [4];
    logic [29:0]   r_q2 [4];
    logic [30:0]   r_t3 [4];

    logic [60:0]   prod1 [4];
    logic [61:0]   prod2 [4];
    logic [37:0]   dq    [4];
    logic [37:0]   rem   [4];
    logic [29:0]   qc    [4];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            prod1[j] = 61'(i_x2[j >> 1]) * 61'(i_t[j]);
            prod2[j] = 62'(r_p1[j]) * 62'(MULS[j]);
            dq[j]    = 38'(r_q2[j]) * 38'(DIVS[j]);
            rem[j]   = 38'(r_p2[j]) - dq[j];
            // estimate is at most one short
            qc[j]    = r_q2[j] + 30'(rem[j] >= 38'(DIVS[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '{1'b0, 1'b0, 1'b0};
        end else if (i_en) begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= i_x;
            r_x[1]  <= r_x[0];
            r_x[2]  <= r_x[1];
            r_x2[0] <= i_x2;
            r_x2[1] <= r_x2[0];
            r_x2[2] <= r_x2[1];
            r_sb[0] <= i_sb;
            r_sb[1] <= r_sb[0];
            r_sb[2] <= r_sb[1];
            for (int j = 0; j < 4; j++) begin
                r_p1[j] <= prod1[j][59:30];
                r_q2[j] <= prod2[j][61:32];
                r_p2[j] <= r_p1[j];
                r_t3[j] <= Q30_ONE - 31'(qc[j]);
            end
        end
    end

    assign o_valid = r_v[2];
    assign o_x     = r_x[2];
    assign o_x2    = r_x2[2];
    assign o_t     = r_t3;
    assign o_sb    = r_sb[2];

endmodule

### hdl/sp2c_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sp2c_div_cell
// One restoring division step: settle one quotient bit per lane.
// ----------------------------------------------------------------------------
module sp2c_div_cell #(
    parameter int unsigned LANES = 1,
    parameter int unsigned DW    = 31,
    parameter int unsigned QW    = 32,
    parameter int unsigned SW    = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem  [LANES],
    input  logic [QW-1:0] i_low  [LANES],
    input  logic [QW-1:0] i_quot [LANES],
    input  logic [DW-1:0] i_div  [LANES],
    input  logic [SW-1:0] i_sb,
    output logic          o_valid,
    output logic [DW-1:0] o_rem  [LANES],
    output logic [QW-1:0] o_low  [LANES],
    output logic [QW-1:0] o_quot [LANES],
    output logic [DW-1:0] o_div  [LANES],
    output logic [SW-1:0] o_sb
);
    logic          r_valid;
    logic [DW-1:0] r_rem  [LANES];
    logic [QW-1:0] r_low  [LANES];
    logic [QW-1:0] r_quot [LANES];
    logic [DW-1:0] r_div  [LANES];
    logic [SW-1:0] r_sb;

    logic [DW:0]   sh   [LANES];
    logic [DW:0]   diff [LANES];
    logic          ge   [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            sh[k]   = {i_rem[k], i_low[k][QW-1]};
            diff[k] = sh[k] - {1'b0, i_div[k]};
            ge[k]   = sh[k] >= {1'b0, i_div[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb <= i_sb;
            for (int k = 0; k < LANES; k++) begin
                r_rem[k]  <= ge[k] ? diff[k][DW-1:0] : sh[k][DW-1:0];
                r_low[k]  <= {i_low[k][QW-2:0], 1'b0};
                r_quot[k] <= {i_quot[k][QW-2:0], ge[k]};
                r_div[k]  <= i_div[k];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_quot  = r_quot;
    assign o_div   = r_div;
    assign o_sb    = r_sb;

endmodule

### hdl/sp2c_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sp2c_sqrt_cell
// One digit-by-digit square root step: settle one root bit from two radicand bits.
// ----------------------------------------------------------------------------
module sp2c_sqrt_cell #(
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [32:0]   i_rem,
    input  logic [30:0]   i_root,
    input  logic [61:0]   i_low,
    input  logic [SW-1:0] i_sb,
    output logic          o_valid,
    output logic [32:0]   o_rem,
    output logic [30:0]   o_root,
    output logic [61:0]   o_low,
    output logic [SW-1:0] o_sb
);
    logic          r_valid;
    logic [32:0]   r_rem;
    logic [30:0]   r_root;
    logic [61:0]   r_low;
    logic [SW-1:0] r_sb;

    logic [34:0]   sh;
    logic [34:0]   trial;
    logic [34:0]   diff;
    logic          ge;

    assign sh    = {i_rem, i_low[61:60]};
    assign trial = {2'b00, i_root, 2'b01};
    assign diff  = sh - trial;
    assign ge    = sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= ge ? diff[32:0] : sh[32:0];
            r_root <= {i_root[29:0], ge};
            r_low  <= {i_low[59:0], 2'b00};
            r_sb   <= i_sb;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_low   = r_low;
    assign o_sb    = r_sb;

endmodule

### hdl/sp2c_tan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sp2c_tan
// Pipelined tangent of two Q1.16 angles: series sine and cosine, then divide.
// ----------------------------------------------------------------------------
module sp2c_tan #(
    parameter int unsigned SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [16:0]   i_angle_a,
    input  logic signed [16:0]   i_angle_b,
    input  logic [SW-1:0]        i_sb,
    output logic                 o_valid,
    output sp2c_pkg::t_tan       o_ta,
    output sp2c_pkg::t_tan       o_tb,
    output logic                 o_na,
    output logic                 o_nb,
    output logic [SW-1:0]        o_sb
);
    import sp2c_pkg::*;

    localparam int unsigned HSW = SW + 2;

    // front end
    logic [16:0]   raw   [2];
    logic [16:0]   mag   [2];
    logic [16:0]   magc  [2];
    logic [59:0]   xsq   [2];

    logic          r_f1_v;
    logic [29:0]   r_f1_x   [2];
    logic          r_f1_neg [2];
    logic [SW-1:0] r_f1_sb;
    logic          r_f2_v;
    logic [29:0]   r_f2_x   [2];
    logic [29:0]   r_f2_x2  [2];
    logic          r_f2_neg [2];
    logic [SW-1:0] r_f2_sb;

    assign raw[0] = i_angle_a;
    assign raw[1] = i_angle_b;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            mag[k]  = raw[k][16] ? 17'(17'd0 - raw[k]) : raw[k];
            // clamp to an eighth turn (pi/4)
            magc[k] = (mag[k] > ANGLE_MAX) ? ANGLE_MAX : mag[k];
            xsq[k]  = 60'(r_f1_x[k]) * 60'(r_f1_x[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (i_en) begin
            r_f1_v <= i_valid;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1_sb <= i_sb;
            r_f2_sb <= r_f1_sb;
            for (int k = 0; k < 2; k++) begin
                r_f1_x[k]   <= {magc[k][15:0], 14'd0};
                r_f1_neg[k] <= raw[k][16];
                r_f2_x[k]   <= r_f1_x[k];
                r_f2_x2[k]  <= xsq[k][59:30];
                r_f2_neg[k] <= r_f1_neg[k];
            end
        end
    end

    // series chain; lanes are sin a, cos a, sin b, cos b
    logic           hv  [HORNER_STEPS+1];
    logic [29:0]    hx  [HORNER_STEPS+1][2];
    logic [29:0]    hx2 [HORNER_STEPS+1][2];
    logic [30:0]    ht  [HORNER_STEPS+1][4];
    logic [HSW-1:0] hsb [HORNER_STEPS+1];

    assign hv[0]  = r_f2_v;
    assign hx[0]  = r_f2_x;
    assign hx2[0] = r_f2_x2;
    assign ht[0]  = '{Q30_ONE, Q30_ONE, Q30_ONE, Q30_ONE};
    assign hsb[0] = {r_f2_sb, r_f2_neg[1], r_f2_neg[0]};

    for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_horner
        sp2c_horner_cell #(
            .SW (HSW),
            .DS (SIN_DIV[g]),
            .DC (COS_DIV[g])
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (hv[g]),
            .i_x     (hx[g]),
            .i_x2    (hx2[g]),
            .i_t     (ht[g]),
            .i_sb    (hsb[g]),
            .o_valid (hv[g+1]),
            .o_x     (hx[g+1]),
            .o_x2    (hx2[g+1]),
            .o_t     (ht[g+1]),
            .o_sb    (hsb[g+1])
        );
    end

    // sine finish
    logic [60:0]    snp [2];
    logic           r_s_v;
    logic [29:0]    r_s_sn [2];
    logic [30:0]    r_s_cs [2];
    logic [HSW-1:0] r_s_sb;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            snp[k] = 61'(hx[HORNER_STEPS][k]) * 61'(ht[HORNER_STEPS][2*k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (i_en) begin
            r_s_v <= hv[HORNER_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_sb <= hsb[HORNER_STEPS];
            for (int k = 0; k < 2; k++) begin
                r_s_sn[k] <= snp[k][59:30];
                r_s_cs[k] <= ht[HORNER_STEPS][2*k+1];
            end
        end
    end

    // divide sine (scaled by 2^30) by cosine
    logic           tv    [TAN_W+1];
    logic [30:0]    trem  [TAN_W+1][2];
    logic [TAN_W-1:0] tlow  [TAN_W+1][2];
    logic [TAN_W-1:0] tquot [TAN_W+1][2];
    logic [30:0]    tdiv  [TAN_W+1][2];
    logic [HSW-1:0] tsb   [TAN_W+1];

    assign tv[0]  = r_s_v;
    assign tsb[0] = r_s_sb;

    for (genvar k = 0; k < 2; k++) begin : g_tan_in
        assign trem[0][k]  = {3'b000, r_s_sn[k][29:2]};
        assign tlow[0][k]  = {r_s_sn[k][1:0], 30'd0};
        assign tquot[0][k] = '0;
        assign tdiv[0][k]  = r_s_cs[k];
    end

    for (genvar g = 0; g < TAN_W; g++) begin : g_div
        sp2c_div_cell #(
            .LANES (2),
            .DW    (31),
            .QW    (TAN_W),
            .SW    (HSW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (tv[g]),
            .i_rem   (trem[g]),
            .i_low   (tlow[g]),
            .i_quot  (tquot[g]),
            .i_div   (tdiv[g]),
            .i_sb    (tsb[g]),
            .o_valid (tv[g+1]),
            .o_rem   (trem[g+1]),
            .o_low   (tlow[g+1]),
            .o_quot  (tquot[g+1]),
            .o_div   (tdiv[g+1]),
            .o_sb    (tsb[g+1])
        );
    end

    assign o_valid = tv[TAN_W];
    assign o_ta    = tquot[TAN_W][0];
    assign o_tb    = tquot[TAN_W][1];
    assign o_na    = tsb[TAN_W][0];
    assign o_nb    = tsb[TAN_W][1];
    assign o_sb    = tsb[TAN_W][HSW-1:2];

endmodule
